@@ rtl/column_zscore_normalizer_top_assert.svh @@
// Assertion macros for the column z-score normalizer.
// Included by the files that carry concurrent checks; needs no package.
`ifndef COLUMN_ZSCORE_NORMALIZER_TOP_ASSERT_SVH
`define COLUMN_ZSCORE_NORMALIZER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, reset-qualified.
`define CZN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("czn: implication check failed");
// Next-cycle implication, reset-qualified.
`define CZN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("czn: next-cycle check failed");
`else
`define CZN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CZN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/czn_pkg.sv @@
// Shared types and constants of the column z-score normalizer.
// Used by czn_lane and column_zscore_normalizer_top; depends on nothing.
`default_nettype none
package czn_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SEL_W       = 10;
  localparam int LANE_MAX    = 4;
  localparam int MASK_W      = 4;
  localparam int WORK_W      = 64;
  localparam int REM_W       = 33;
  localparam int DIVR_W      = 32;
  localparam int MANT_W      = 18;
  localparam int EXP_W       = 6;
  localparam int INV_W       = 24;
  localparam int STEP_W      = 7;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 35;
  localparam int NORM_SHIFT  = 46;
  localparam int SCALE_POINT = 50;
  localparam int EXP_TOP     = 60;
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_BIT0   = 62;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] feature_a;
    logic signed [SAMPLE_W-1:0] feature_b;
    logic signed [SAMPLE_W-1:0] feature_c;
    logic signed [SAMPLE_W-1:0] feature_d;
    logic                       last_row;
    logic [SEL_W-1:0]           row_select;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scaled_a;
    logic signed [SAMPLE_W-1:0] scaled_b;
    logic signed [SAMPLE_W-1:0] scaled_c;
    logic signed [SAMPLE_W-1:0] scaled_d;
    logic [MASK_W-1:0]          unscaled_mask;
    logic                       read_error;
  } out_item_t;

  typedef enum logic [3:0] {
    LS_IDLE, LS_INIT, LS_NMUL, LS_SQR, LS_DIFF, LS_MDIV, LS_MEAN,
    LS_SQRT, LS_QSET, LS_QDIV, LS_NORM, LS_DONE
  } lane_state_t;

  typedef struct packed {
    logic acc_clear;
    logic acc_add;
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic zero_var;
  } lane_sts_t;

endpackage
`default_nettype wire

@@ rtl/czn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the loaded rows; depends on nothing.
`default_nettype none
module czn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/czn_lane.sv @@
// One feature column: running sums, serial statistics engine and scaling path.
// Depends on czn_pkg.
`default_nettype none
module czn_lane #(
  parameter int CNT_W = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire czn_pkg::lane_ctl_t                  ctl,
  input  wire logic signed [czn_pkg::SAMPLE_W-1:0] load_sample,
  input  wire logic [CNT_W-1:0]                    row_count,
  input  wire logic signed [czn_pkg::SAMPLE_W-1:0] rd_sample,
  output czn_pkg::lane_sts_t                       sts,
  output logic signed [czn_pkg::SAMPLE_W-1:0]      scaled
);

  localparam int SW  = czn_pkg::SAMPLE_W;
  localparam int WW  = czn_pkg::WORK_W;
  localparam int S1W = SW + CNT_W;
  localparam int S2W = 2 * SW + CNT_W;

  czn_pkg::lane_state_t state_r, state_nxt;

  logic signed [S1W-1:0]              s1_r;
  logic [S2W-1:0]                     s2_r;
  logic signed [S1W-1:0]              x_ext;
  logic signed [2*SW-1:0]             x_sq;
  logic [S1W-1:0]                     mag;

  logic [czn_pkg::STEP_W-1:0]         step_r;
  logic [czn_pkg::STEP_W-1:0]         z_r;
  logic [WW-1:0]                      acc_r, mcand_r, sq_r, d_r;
  logic [WW-1:0]                      dvd_r, quo_r, res_r, bit_r;
  logic [CNT_W-1:0]                   mplier_r;
  logic [czn_pkg::REM_W-1:0]          rem_r;
  logic [czn_pkg::DIVR_W-1:0]         dvsr_r;

  logic signed [SW-1:0]               mean_r;
  logic signed [SW-1:0]               mean_nxt;
  logic [czn_pkg::INV_W-1:0]          inv_r;
  logic                               zv_r;

  logic [czn_pkg::REM_W-1:0]          rem_sh, rem_new;
  logic                               div_ge;
  logic [WW-1:0]                      sq_try;
  logic                               sq_ge;
  logic                               step_end;
  logic                               d_zero, quo_zero;
  logic [SW:0]                        q_mean;

  // Running column sums, updated as rows are stored.
  assign x_ext = S1W'(load_sample);
  assign x_sq  = load_sample * load_sample;
  assign mag   = s1_r[S1W-1] ? S1W'(-s1_r) : S1W'(s1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (ctl.acc_clear || ctl.acc_add) begin
      s1_r <= (ctl.acc_clear ? '0 : s1_r) + (ctl.acc_add ? x_ext : '0);
      s2_r <= (ctl.acc_clear ? '0 : s2_r) + (ctl.acc_add ? S2W'(unsigned'(x_sq)) : '0);
    end
  end

  // Shared one-bit-per-cycle restoring divider and square root steps.
  assign rem_sh   = {rem_r[czn_pkg::REM_W-2:0], dvd_r[WW-1]};
  assign div_ge   = rem_sh >= czn_pkg::REM_W'(dvsr_r);
  assign rem_new  = div_ge ? rem_sh - czn_pkg::REM_W'(dvsr_r) : rem_sh;
  assign sq_try   = res_r + bit_r;
  assign sq_ge    = acc_r >= sq_try;
  assign d_zero   = d_r == '0;
  assign quo_zero = quo_r == '0;
  assign q_mean   = quo_r[SW:0];
  assign mean_nxt = s1_r[S1W-1] ? SW'(-q_mean) : SW'(q_mean);

  // State outputs.
  always_comb begin
    sts.busy = state_r != czn_pkg::LS_IDLE;
    sts.zero_var = zv_r;
    case (state_r)
      czn_pkg::LS_NMUL: step_end = step_r == czn_pkg::STEP_W'(CNT_W - 1);
      czn_pkg::LS_MDIV: step_end = step_r == czn_pkg::STEP_W'(WW - 1);
      czn_pkg::LS_QDIV: step_end = step_r == czn_pkg::STEP_W'(WW - 1);
      czn_pkg::LS_SQRT: step_end = step_r == czn_pkg::STEP_W'(czn_pkg::SQRT_STEPS - 1);
      default:          step_end = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      czn_pkg::LS_IDLE: if (ctl.start) state_nxt = czn_pkg::LS_INIT;
      czn_pkg::LS_INIT: state_nxt = czn_pkg::LS_NMUL;
      czn_pkg::LS_NMUL: if (step_end) state_nxt = czn_pkg::LS_SQR;
      czn_pkg::LS_SQR:  state_nxt = czn_pkg::LS_DIFF;
      czn_pkg::LS_DIFF: state_nxt = czn_pkg::LS_MDIV;
      czn_pkg::LS_MDIV: if (step_end) state_nxt = czn_pkg::LS_MEAN;
      czn_pkg::LS_MEAN: state_nxt = d_zero ? czn_pkg::LS_DONE : czn_pkg::LS_SQRT;
      czn_pkg::LS_SQRT: if (step_end) state_nxt = czn_pkg::LS_QSET;
      czn_pkg::LS_QSET: state_nxt = czn_pkg::LS_QDIV;
      czn_pkg::LS_QDIV: if (step_end) state_nxt = czn_pkg::LS_NORM;
      czn_pkg::LS_NORM: if (quo_zero || quo_r[WW-1]) state_nxt = czn_pkg::LS_DONE;
      czn_pkg::LS_DONE: state_nxt = czn_pkg::LS_IDLE;
      default:          state_nxt = czn_pkg::LS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= czn_pkg::LS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Statistics datapath: n*S2 by shift and add, S1 squared, D, mean by
  // division, floor square root of D, n*2^46/r, then normalization.
  always_ff @(posedge clk) begin
    case (state_r)
      czn_pkg::LS_INIT: begin
        acc_r    <= '0;
        mcand_r  <= WW'(s2_r);
        mplier_r <= row_count;
        step_r   <= '0;
      end
      czn_pkg::LS_NMUL: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        step_r   <= step_r + 1'b1;
      end
      czn_pkg::LS_SQR: begin
        sq_r <= WW'(mag * mag);
      end
      czn_pkg::LS_DIFF: begin
        d_r    <= acc_r - sq_r;
        dvd_r  <= WW'(mag) + WW'(row_count >> 1);
        dvsr_r <= czn_pkg::DIVR_W'(row_count);
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
      end
      czn_pkg::LS_MDIV, czn_pkg::LS_QDIV: begin
        rem_r  <= rem_new;
        dvd_r  <= dvd_r << 1;
        quo_r  <= {quo_r[WW-2:0], div_ge};
        step_r <= step_r + 1'b1;
      end
      czn_pkg::LS_MEAN: begin
        acc_r  <= d_r;
        res_r  <= '0;
        bit_r  <= WW'(1) << czn_pkg::SQRT_BIT0;
        step_r <= '0;
      end
      czn_pkg::LS_SQRT: begin
        if (sq_ge) begin
          acc_r <= acc_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 1'b1;
      end
      czn_pkg::LS_QSET: begin
        dvd_r  <= WW'(row_count) << czn_pkg::NORM_SHIFT;
        dvsr_r <= res_r[czn_pkg::DIVR_W-1:0];
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
        z_r    <= '0;
      end
      czn_pkg::LS_NORM: begin
        if (!quo_r[WW-1] && !quo_zero) begin
          quo_r <= quo_r << 1;
          z_r   <= z_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Column statistics seen by the scaling path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      inv_r  <= '0;
      zv_r   <= 1'b0;
    end else begin
      case (state_r)
        czn_pkg::LS_MEAN: mean_r <= mean_nxt;
        czn_pkg::LS_DONE: begin
          zv_r <= d_zero;
          if (d_zero || quo_zero) begin
            inv_r <= '0;
          end else begin
            inv_r <= {czn_pkg::EXP_W'(czn_pkg::STEP_W'(czn_pkg::EXP_TOP) - z_r),
                      quo_r[WW-1 -: czn_pkg::MANT_W]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scaling: product stage, then round, shift and saturate.
  logic signed [czn_pkg::DIFF_W-1:0] diff;
  logic [czn_pkg::DIFF_W-1:0]        dm;
  logic                              neg_r;
  logic [czn_pkg::PROD_W-1:0]        prod_r;
  logic signed [SW-1:0]              raw_r;
  logic [czn_pkg::EXP_W-1:0]         expo, sh;
  logic [WW-1:0]                     p64, pr, limit;

  assign diff = czn_pkg::DIFF_W'(rd_sample) - czn_pkg::DIFF_W'(mean_r);
  assign dm   = diff[czn_pkg::DIFF_W-1] ? czn_pkg::DIFF_W'(-diff) : czn_pkg::DIFF_W'(diff);

  always_ff @(posedge clk) begin
    neg_r  <= diff[czn_pkg::DIFF_W-1];
    prod_r <= czn_pkg::PROD_W'(dm * inv_r[czn_pkg::MANT_W-1:0]);
    raw_r  <= rd_sample;
  end

  always_comb begin
    expo  = inv_r[czn_pkg::INV_W-1 -: czn_pkg::EXP_W];
    p64   = WW'(prod_r);
    limit = neg_r ? WW'(32768) : WW'(32767);
    if (expo <= czn_pkg::EXP_W'(czn_pkg::SCALE_POINT)) begin
      sh = czn_pkg::EXP_W'(czn_pkg::SCALE_POINT) - expo;
      if (sh == '0) begin
        pr = p64;
      end else begin
        pr = (p64 + (WW'(1) << (sh - 1'b1))) >> sh;
      end
    end else begin
      sh = expo - czn_pkg::EXP_W'(czn_pkg::SCALE_POINT);
      if (p64 != '0 && p64 > (limit >> sh)) begin
        pr = limit;
      end else begin
        pr = p64 << sh;
      end
    end
    if (pr > limit) begin
      pr = limit;
    end
    if (zv_r) begin
      scaled = raw_r;
    end else if (neg_r) begin
      scaled = SW'(-pr);
    end else begin
      scaled = SW'(pr);
    end
  end

endmodule
`default_nettype wire

@@ rtl/column_zscore_normalizer_top.sv @@
// Top level of the column z-score normalizer: row store, feature lanes and
// the result merge. Depends on czn_pkg, czn_ram, czn_lane and the assert header.
//
//  Channel | Ports                      | Handshake
//  --------+----------------------------+----------------------------------------
//  input   | start, busy, in_item       | item taken at an edge with start & !busy
//  result  | out_valid, out_item        | one-cycle strobe, receiver cannot stall
//
// Load and read items are each taken one per clock cycle while busy is low. A
// read item gives its result through the RAM read, product stage and output
// register; reads overlap in that pipeline. A load item that carries last_row
// starts the statistics pass, during which busy is high: each lane runs a
// bit-serial multiply over the bits of the row count and a 64-step restoring
// division for the mean and, unless the column has zero variance, a 32-step
// square root, a second 64-step restoring division and a normalizing shift.
// The result channel has no stall, so nothing else holds items off. Reset is
// synchronous and active low; the row store is not cleared, since rows are
// read only after being written.
`default_nettype none
`include "column_zscore_normalizer_top_assert.svh"
module column_zscore_normalizer_top #(
  parameter int MAX_ROWS      = 1024,
  parameter int FEATURE_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire czn_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output czn_pkg::out_item_t      out_item
);

  localparam int SW    = czn_pkg::SAMPLE_W;
  localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int CMP_W = CNT_W + czn_pkg::SEL_W;
  localparam int RAM_W = FEATURE_COUNT * SW;

  logic [CNT_W-1:0]  rows_loaded_r, rows_loaded_nxt, count_base;
  logic              set_closed_r, set_closed_nxt;
  logic              ld_acc, rd_acc, store, rd_err;
  logic [CMP_W-1:0]  sel_wide;
  logic              v1_r, e1_r, v2_r, e2_r;
  logic              out_valid_r;
  czn_pkg::out_item_t out_item_r, out_item_nxt;

  logic signed [SW-1:0] feat [czn_pkg::LANE_MAX];
  logic signed [SW-1:0] sc   [czn_pkg::LANE_MAX];
  logic [czn_pkg::LANE_MAX-1:0] zvm, lane_busy;
  logic [RAM_W-1:0]     wdata, rdata;
  czn_pkg::lane_ctl_t   lane_ctl;

  // Input decode.
  assign ld_acc = start && !busy && (in_item.command == czn_pkg::CMD_LOAD);
  assign rd_acc = start && !busy && (in_item.command == czn_pkg::CMD_READ);

  // A load after a closed set starts a new one; a full store drops the row.
  assign count_base = set_closed_r ? '0 : rows_loaded_r;
  assign store      = ld_acc && (count_base < CNT_W'(MAX_ROWS));

  always_comb begin
    rows_loaded_nxt = rows_loaded_r;
    set_closed_nxt  = set_closed_r;
    if (ld_acc) begin
      rows_loaded_nxt = store ? count_base + 1'b1 : count_base;
      set_closed_nxt  = in_item.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r <= '0;
      set_closed_r  <= 1'b0;
    end else begin
      rows_loaded_r <= rows_loaded_nxt;
      set_closed_r  <= set_closed_nxt;
    end
  end

  assign lane_ctl.acc_clear = ld_acc && set_closed_r;
  assign lane_ctl.acc_add   = store;
  assign lane_ctl.start     = ld_acc && in_item.last_row;

  // Row store.
  assign feat[0] = in_item.feature_a;
  assign feat[1] = in_item.feature_b;
  assign feat[2] = in_item.feature_c;
  assign feat[3] = in_item.feature_d;

  assign sel_wide = CMP_W'(in_item.row_select);
  assign rd_err   = !set_closed_r || (sel_wide >= CMP_W'(rows_loaded_r));

  czn_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_ROWS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (store),
    .waddr(count_base[AW-1:0]),
    .wdata(wdata),
    .raddr(sel_wide[AW-1:0]),
    .rdata(rdata)
  );

  // Feature lanes; lanes past the feature count read as zero.
  for (genvar k = 0; k < czn_pkg::LANE_MAX; k++) begin : g_lane
    if (k < FEATURE_COUNT) begin : g_on
      czn_pkg::lane_sts_t sts;
      assign wdata[k*SW +: SW] = feat[k];
      czn_lane #(.CNT_W(CNT_W)) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl),
        .load_sample(feat[k]),
        .row_count  (rows_loaded_r),
        .rd_sample  (rdata[k*SW +: SW]),
        .sts        (sts),
        .scaled     (sc[k])
      );
      assign lane_busy[k] = sts.busy;
      assign zvm[k]       = sts.zero_var;
    end else begin : g_off
      assign sc[k]        = '0;
      assign lane_busy[k] = 1'b0;
      assign zvm[k]       = 1'b0;
    end
  end

  assign busy = |lane_busy;

  // Read pipeline control and result merge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= rd_acc;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_r       <= rd_err;
    e2_r       <= e1_r;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    out_item_nxt = '0;
    if (e2_r) begin
      out_item_nxt.read_error = 1'b1;
    end else begin
      out_item_nxt.scaled_a      = sc[0];
      out_item_nxt.scaled_b      = sc[1];
      out_item_nxt.scaled_c      = sc[2];
      out_item_nxt.scaled_d      = sc[3];
      out_item_nxt.unscaled_mask = zvm;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks.
  `CZN_ASSERT_IMP(a_rd_latency, clk, rst_n, rd_acc, ##3 out_valid)
  `CZN_ASSERT_IMP(a_out_source, clk, rst_n, out_valid, $past(rd_acc, 3))
  `CZN_ASSERT_NXT(a_pass_starts, clk, rst_n, ld_acc && in_item.last_row, busy)
  `CZN_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(ld_acc && in_item.last_row))
  `CZN_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, rows_loaded_r <= CNT_W'(MAX_ROWS))
  `CZN_ASSERT_IMP(a_ok_closed, clk, rst_n, out_valid && !out_item.read_error, $past(set_closed_r, 3))

endmodule
`default_nettype wire

@@ tb/column_zscore_normalizer_checker.sv @@
// Checker for the column z-score normalizer: watches both channels, predicts
// each read result from the accepted items and compares. Depends on czn_pkg.
module column_zscore_normalizer_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire czn_pkg::in_item_t  in_item,
  input  wire logic               out_valid,
  input  wire czn_pkg::out_item_t out_item,
  output int                      fail_count,
  output int                      rows_pending
);
  import czn_pkg::*;

  localparam int STORE_DEPTH = 1024;

  logic signed [SAMPLE_W-1:0] row_copy [STORE_DEPTH][LANE_MAX];
  int unsigned                row_count;
  longint                     col_mean [LANE_MAX];
  logic [INV_W-1:0]           col_inv [LANE_MAX];
  logic [MASK_W-1:0]          flat_mask;
  logic                       stats_ready;
  out_item_t                  scaled_rows_due [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Mean, zero-variance test and the floating inverse deviation of one column.
  task automatic column_stats(input int col);
    longint          s1, xv;
    longint unsigned s2, mag, n, d, r, q, mant;
    int              len;
    s1 = 0;
    s2 = 0;
    n = row_count;
    for (int i = 0; i < row_count; i++) begin
      xv = row_copy[i][col];
      s1 += xv;
      s2 += longint'(xv * xv);
    end
    mag = (s1 < 0) ? -s1 : s1;
    if (n == 0) col_mean[col] = 0;
    else col_mean[col] = (s1 < 0) ? -longint'((mag + n / 2) / n) : longint'((mag + n / 2) / n);
    d = n * s2 - mag * mag;
    if (d == 0) begin
      flat_mask[col] = 1'b1;
      col_inv[col] = '0;
      return;
    end
    r = int_sqrt(d);
    q = (n << NORM_SHIFT) / r;
    if (q == 0) begin
      col_inv[col] = '0;
      return;
    end
    len = 0;
    while (len < 64 && (q >> len) != 0) len++;
    if (len > MANT_W) mant = q >> (len - MANT_W);
    else mant = q << (MANT_W - len);
    col_inv[col] = {6'(len - 4), mant[MANT_W-1:0]};
  endtask

  function automatic logic [SAMPLE_W-1:0] standardize(input longint xv, input int col);
    longint          diff;
    longint unsigned dm, p, lim;
    int              e, sh;
    diff = xv - col_mean[col];
    dm = (diff < 0) ? -diff : diff;
    e = col_inv[col][INV_W-1:MANT_W];
    sh = SCALE_POINT - e;
    p = dm * col_inv[col][MANT_W-1:0];
    lim = (diff < 0) ? 32768 : 32767;
    if (sh > 0) begin
      if (sh >= 63) p = 0;
      else p = (p + (64'd1 << (sh - 1))) >> sh;
    end else if (sh < 0) begin
      if (p != 0 && (sh < -20 || p > (lim >> (-sh)))) p = lim;
      else p = p << (-sh);
    end
    if (p > lim) p = lim;
    if (diff < 0) p = -p;
    return p[SAMPLE_W-1:0];
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    logic signed [SAMPLE_W-1:0] feats [LANE_MAX];
    if (!rst_n) begin
      row_count = 0;
      flat_mask = '0;
      stats_ready = 1'b0;
      fail_count = 0;
      scaled_rows_due.delete();
      rows_pending = 0;
      for (int k = 0; k < LANE_MAX; k++) begin
        col_mean[k] = 0;
        col_inv[k] = '0;
      end
    end else begin
      if (out_valid) begin
        if (scaled_rows_due.size() == 0) begin
          report("unexpected result", longint'(out_item.read_error), 0);
        end else begin
          want = scaled_rows_due.pop_front();
          if (out_item.scaled_a !== want.scaled_a) report("scaled_a", out_item.scaled_a, want.scaled_a);
          if (out_item.scaled_b !== want.scaled_b) report("scaled_b", out_item.scaled_b, want.scaled_b);
          if (out_item.scaled_c !== want.scaled_c) report("scaled_c", out_item.scaled_c, want.scaled_c);
          if (out_item.scaled_d !== want.scaled_d) report("scaled_d", out_item.scaled_d, want.scaled_d);
          if (out_item.unscaled_mask !== want.unscaled_mask)
            report("unscaled_mask", out_item.unscaled_mask, want.unscaled_mask);
          if (out_item.read_error !== want.read_error)
            report("read_error", out_item.read_error, want.read_error);
        end
      end
      if (start && !busy) begin
        feats[0] = in_item.feature_a;
        feats[1] = in_item.feature_b;
        feats[2] = in_item.feature_c;
        feats[3] = in_item.feature_d;
        if (in_item.command == CMD_LOAD) begin
          if (stats_ready) begin
            stats_ready = 1'b0;
            row_count = 0;
          end
          if (row_count < STORE_DEPTH) begin
            for (int k = 0; k < LANE_MAX; k++) row_copy[row_count][k] = feats[k];
            row_count++;
          end
          if (in_item.last_row) begin
            flat_mask = '0;
            for (int k = 0; k < LANE_MAX; k++) column_stats(k);
            stats_ready = 1'b1;
          end
        end else begin
          want = '0;
          if (!stats_ready || in_item.row_select >= row_count) begin
            want.read_error = 1'b1;
          end else begin
            for (int k = 0; k < LANE_MAX; k++)
              feats[k] = flat_mask[k] ? row_copy[in_item.row_select][k]
                                      : standardize(row_copy[in_item.row_select][k], k);
            want.scaled_a = feats[0];
            want.scaled_b = feats[1];
            want.scaled_c = feats[2];
            want.scaled_d = feats[3];
            want.unscaled_mask = flat_mask;
          end
          scaled_rows_due.push_back(want);
        end
      end
      rows_pending = scaled_rows_due.size();
    end
  end
endmodule

@@ tb/tb_column_zscore_normalizer_top.sv @@
// Testbench top of the column z-score normalizer: drives load and read items
// and gives the verdict. Depends on czn_pkg, the block and the checker.
module tb_column_zscore_normalizer_top;
  import czn_pkg::*;

  localparam int ITEM_GOAL = 1550;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        rows_pending;
  int        items_sent;

  // Per-set, per-column flavor of the feature values.
  int        col_mode [LANE_MAX];
  logic [SAMPLE_W-1:0] col_base [LANE_MAX];

  column_zscore_normalizer_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  column_zscore_normalizer_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers one item after a random gap, or none when no_gap is set, and holds it until the block takes it.
  // The busy level seen at the falling edge is the one the next rising edge sees.
  task automatic send(input in_item_t item, input bit no_gap);
    int  gap;
    bit  took;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_item <= in_item_t'({$urandom, $urandom, $urandom});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= item;
    do begin
      took = !busy;
      @(posedge clk);
      if (!took) @(negedge clk);
    end while (!took);
    items_sent++;
  endtask

  // One feature value shaped by the column flavor of the current set.
  function automatic logic [SAMPLE_W-1:0] feature_value(input int col);
    case (col_mode[col])
      0: return SAMPLE_W'($urandom);
      1: return col_base[col];
      2: return col_base[col] + SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
      default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic pick_flavors();
    for (int k = 0; k < LANE_MAX; k++) begin
      col_mode[k] = $urandom_range(0, 3);
      col_base[k] = SAMPLE_W'($urandom);
    end
  endtask

  task automatic load_row(input bit last, input bit no_gap);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.command = CMD_LOAD;
    it.feature_a = feature_value(0);
    it.feature_b = feature_value(1);
    it.feature_c = feature_value(2);
    it.feature_d = feature_value(3);
    it.last_row = last;
    send(it, no_gap);
  endtask

  task automatic read_row(input logic [SEL_W-1:0] sel, input bit no_gap);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.command = CMD_READ;
    it.row_select = sel;
    send(it, no_gap);
  endtask

  // Loads one set of rows and reads some of them back, mostly inside the set.
  task automatic run_set(input int rows, input int reads);
    bit tight;
    tight = ($urandom_range(0, 3) == 0);
    pick_flavors();
    for (int i = 0; i < rows; i++) begin
      // Occasionally a read while the set is still open.
      if ($urandom_range(0, 15) == 0) read_row(SEL_W'($urandom), tight);
      load_row(i == rows - 1, tight);
    end
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(0, 7) == 0) read_row(SEL_W'($urandom), tight);
      else read_row(SEL_W'($urandom_range(0, rows > 1024 ? 1023 : rows - 1)), tight);
    end
  endtask

  initial begin
    in_item_t it;
    int       rows;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A read before any set is closed must report an error.
    read_row(10'd0, 1'b0);
    // Extreme values, a constant column and a read with last_row set.
    col_mode = '{3, 1, 0, 2};
    col_base = '{16'h0, 16'h8000, 16'h0, 16'h7FF8};
    it = '0;
    it.command = CMD_LOAD;
    it.feature_a = 16'sh8000;
    it.feature_b = 16'sh8000;
    it.feature_c = 16'sh7FFF;
    it.feature_d = 16'sh0000;
    send(it, 1'b0);
    it.feature_a = 16'sh7FFF;
    it.feature_c = 16'sh8000;
    send(it, 1'b1);
    load_row(1'b0, 1'b1);
    load_row(1'b1, 1'b1);
    it = '0;
    it.command = CMD_READ;
    it.last_row = 1'b1;
    it.row_select = 10'd1;
    send(it, 1'b1);
    for (int i = 0; i < 4; i++) read_row(SEL_W'(i), 1'b1);
    // Out of range rows, the top index among them.
    read_row(10'd4, 1'b0);
    read_row(10'h3FF, 1'b0);
    // A single-row set has zero variance everywhere.
    load_row(1'b1, 1'b0);
    read_row(10'd0, 1'b0);
    read_row(10'd1, 1'b0);
    // Loading after a closed set opens a new one, so reads fail until closed.
    load_row(1'b0, 1'b0);
    read_row(10'd0, 1'b0);
    load_row(1'b1, 1'b0);
    read_row(10'd1, 1'b0);

    // A store overrun once: rows past the depth are dropped, last_row still closes.
    run_set(1027, 40);

    // Random sets, mostly small.
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: rows = $urandom_range(9, 60);
        1: rows = 1;
        default: rows = $urandom_range(2, 8);
      endcase
      run_set(rows, $urandom_range(1, 2 * rows + 2));
    end

    @(negedge clk);
    start <= 1'b0;
    while (rows_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("** column_zscore_normalizer_top: PASSED **");
    end else begin
      $display("** column_zscore_normalizer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** column_zscore_normalizer_top: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/czn_pkg.sv
rtl/czn_ram.sv
rtl/czn_lane.sv
rtl/column_zscore_normalizer_top.sv
tb/column_zscore_normalizer_checker.sv
tb/tb_column_zscore_normalizer_top.sv
